// File: rtl/core/clcd_pkg.sv
// Shared types, constants and the microcode table for the LCD nibble interface.
// No dependencies; the sequencer, datapath and top level import this package.
package clcd_pkg;

    localparam int PC_W = 7;

    // Program layout: the init program sits at 0..56, the byte program at 57..64.
    localparam logic [PC_W-1:0] PC_INIT = 7'd0;
    localparam logic [PC_W-1:0] PC_BYTE = 7'd57;
    localparam logic [PC_W-1:0] PC_INIT_BYTES = 7'd17;
    localparam logic [PC_W-1:0] PC_INIT_LAST = 7'd56;
    localparam logic [PC_W-1:0] PC_BYTE_LAST = 7'd64;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] DDRAM_ROW1 = 8'h40;

    localparam logic [3:0] HOLD_PHASE = 4'd1;
    localparam logic [3:0] HOLD_POWER_UP = 4'd15;
    localparam logic [3:0] HOLD_NONE = 4'd0;

    localparam logic [7:0] INIT_BYTES [5] = '{8'h28, 8'h08, 8'h01, 8'h02, 8'h0C};
    localparam logic [3:0] INIT_NIBS [4] = '{4'h3, 4'h3, 4'h3, 4'h2};
    localparam logic [3:0] INIT_WAITS [4] = '{4'd5, 4'd1, 4'd1, 4'd1};

    typedef enum logic [1:0] {
        REQ_INIT   = 2'd0,
        REQ_CMD    = 2'd1,
        REQ_CHAR   = 2'd2,
        REQ_CURSOR = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_RS,
        OP_EN_HI,
        OP_DATA,
        OP_EN_LO
    } t_op;

    typedef enum logic [1:0] {
        NSRC_CONST,
        NSRC_HI,
        NSRC_LO
    } t_nsrc;

    typedef struct packed {
        t_op        op;
        t_nsrc      nsrc;
        logic [3:0] nib;
        logic [3:0] hold;
        logic       rs_req;   // RS comes from the request rather than zero
        logic       last;     // final word of a program
    } t_cw;

    typedef struct packed {
        logic       adv;      // issue the current word this cycle
        t_cw        cw;
        logic       ld;       // load byte and RS mode from an accepted request
        logic       ld_rs;
        logic [7:0] ld_byte;
    } t_ctl;

    typedef struct packed {
        logic            busy;
        logic [PC_W-1:0] pc;
    } t_seq_stat;

    function automatic t_op phase_op(input logic [1:0] ph);
        t_op o;
        case (ph)
            2'd0:    o = OP_RS;
            2'd1:    o = OP_EN_HI;
            2'd2:    o = OP_DATA;
            default: o = OP_EN_LO;
        endcase
        return o;
    endfunction

    // Microcode ROM, one control word per pin phase.
    function automatic t_cw rom_word(input logic [PC_W-1:0] a);
        t_cw w;
        logic [PC_W-1:0] r;
        logic [1:0] ph;
        logic [1:0] ni;
        logic [2:0] bi;
        w = '{op: OP_WAIT, nsrc: NSRC_CONST, nib: 4'h0, hold: HOLD_PHASE,
              rs_req: 1'b0, last: 1'b0};
        r = '0;
        if (a == PC_INIT) begin
            w.hold = HOLD_POWER_UP;
        end else if (a < PC_INIT_BYTES) begin
            r = a - 7'd1;
            ph = r[1:0];
            ni = r[3:2];
            w.op = phase_op(ph);
            w.nib = INIT_NIBS[ni];
            if (ph == 2'd3) begin
                w.hold = INIT_WAITS[ni];
            end
        end else if (a <= PC_INIT_LAST) begin
            r = a - PC_INIT_BYTES;
            ph = r[1:0];
            bi = r[5:3];
            w.op = phase_op(ph);
            w.nib = r[2] ? INIT_BYTES[bi][3:0] : INIT_BYTES[bi][7:4];
            if (ph == 2'd3) begin
                w.hold = (r[2] && bi < 3'd4) ? HOLD_PHASE : HOLD_NONE;
            end
            w.last = (a == PC_INIT_LAST);
        end else if (a <= PC_BYTE_LAST) begin
            r = a - PC_BYTE;
            ph = r[1:0];
            w.op = phase_op(ph);
            w.nsrc = r[2] ? NSRC_LO : NSRC_HI;
            w.rs_req = 1'b1;
            if (ph == 2'd3) begin
                w.hold = HOLD_NONE;
            end
            w.last = (a == PC_BYTE_LAST);
        end else begin
            w.last = 1'b1;
        end
        return w;
    endfunction

endpackage

// File: rtl/core/clcd_req_if.sv
// Request channel: valid/ready handshake carrying one LCD request per beat.
// Depends on nothing.
interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] byte_value;
    logic [1:0] cursor_row;
    logic [4:0] cursor_column;

    modport source (output valid, req_type, byte_value, cursor_row, cursor_column,
                    input ready);
    modport sink (input valid, req_type, byte_value, cursor_row, cursor_column,
                  output ready);
endinterface

// File: rtl/core/clcd_res_if.sv
// Result channel: valid/ready handshake carrying one pin phase per beat.
// Depends on nothing.
interface clcd_res_if;
    logic       valid;
    logic       ready;
    logic       rs_pin;
    logic       enable_pin;
    logic [3:0] data_pins;
    logic [3:0] hold_ms;
    logic       last_phase;

    modport source (output valid, rs_pin, enable_pin, data_pins, hold_ms, last_phase,
                    input ready);
    modport sink (input valid, rs_pin, enable_pin, data_pins, hold_ms, last_phase,
                  output ready);
endinterface

// File: rtl/core/char_lcd_nibble_interface_unit.sv
// Character LCD 4-bit bus interface: top level.
// Depends on clcd_pkg, clcd_req_if, clcd_res_if, clcd_seq and clcd_datapath.
//
// Usage:
//   i_req takes one request per beat: power-up init, command byte, character
//   byte or cursor move (row/column). o_res gives one beat per pin phase with
//   the RS, enable and data levels after that phase and the time in ms to hold
//   it; last_phase marks the final beat of a request.
//   A nibble is four phases (RS, enable high, data, enable low); a byte is two
//   nibbles, high first, so 8 beats. Init is a 15 ms wait, four single nibbles
//   and five bytes: 57 beats. A cursor move outside the display gives no beats.
//   An accepted request loads the step counter, and each issued word is then
//   registered into the result register. One beat is issued per cycle from the
//   microcode step counter while the sink does not stall.
//   i_req.ready is high only while the sequencer is idle; the next request may
//   be taken while the final beat of the previous one still waits in o_res.
//   A stall on o_res freezes the step counter and the pins; nothing is lost.
//   Reset (synchronous, active low) clears pin levels to zero and the
//   sequencer to idle. The real-time holds are the downstream timer's job.
module char_lcd_nibble_interface_unit #(
    parameter int DISPLAY_ROWS    = 2,
    parameter int DISPLAY_COLUMNS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clcd_req_if.sink   i_req,
    clcd_res_if.source o_res
);
    import clcd_pkg::*;

    t_ctl      ctl;
    t_seq_stat stat;
    logic      out_free;

    clcd_seq #(
        .DISPLAY_ROWS    (DISPLAY_ROWS),
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_out_free (out_free),
        .o_ctl      (ctl),
        .o_stat     (stat)
    );

    clcd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_out_free (out_free),
        .o_res      (o_res)
    );

    // a program's final word returns the sequencer to idle
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.adv && ctl.cw.last) |=> !stat.busy)
        else $error("sequencer still running after last phase");

    // an out-of-range cursor move must not start a program
    a_cursor_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.req_type == REQ_CURSOR)
         && ({1'b0, i_req.cursor_row} >= 3'(DISPLAY_ROWS)))
        |=> !stat.busy)
        else $error("rejected cursor move started a program");

    // step counter stays inside the program
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> (stat.pc <= PC_BYTE_LAST))
        else $error("step counter beyond the microcode table");

    // beats are only issued when the result register can take them
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.adv |-> (out_free && stat.busy))
        else $error("phase issued into a full result register");
endmodule

// File: rtl/core/clcd_seq.sv
// Microcode sequencer: request dispatch, step counter and ROM fetch.
// Depends on clcd_pkg and clcd_req_if.
module clcd_seq #(
    parameter int DISPLAY_ROWS    = 2,
    parameter int DISPLAY_COLUMNS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    clcd_req_if.sink            i_req,
    input  logic                i_out_free,
    output clcd_pkg::t_ctl      o_ctl,
    output clcd_pkg::t_seq_stat o_stat
);
    import clcd_pkg::*;

    localparam logic [2:0] ROWS_L = 3'(DISPLAY_ROWS);
    localparam logic [5:0] COLS_L = 6'(DISPLAY_COLUMNS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            acc;
    logic            cursor_ok;
    t_req            req;
    t_cw             cw;

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign req         = t_req'(i_req.req_type);
    assign cursor_ok   = ({1'b0, i_req.cursor_row} < ROWS_L)
                      && ({1'b0, i_req.cursor_column} < COLS_L);
    assign cw          = rom_word(r_pc);

    always_comb begin
        n_state       = r_state;
        n_pc          = r_pc;
        o_ctl.adv     = 1'b0;
        o_ctl.cw      = cw;
        o_ctl.ld      = 1'b0;
        o_ctl.ld_rs   = 1'b0;
        o_ctl.ld_byte = i_req.byte_value;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (req)
                        REQ_INIT: begin
                            n_pc    = PC_INIT;
                            n_state = S_RUN;
                        end
                        REQ_CMD, REQ_CHAR: begin
                            n_pc        = PC_BYTE;
                            n_state     = S_RUN;
                            o_ctl.ld    = 1'b1;
                            o_ctl.ld_rs = (req == REQ_CHAR);
                        end
                        default: begin
                            // out-of-range cursor: dropped, no phases
                            if (cursor_ok) begin
                                n_pc          = PC_BYTE;
                                n_state       = S_RUN;
                                o_ctl.ld      = 1'b1;
                                o_ctl.ld_byte = CMD_SET_DDRAM
                                    | ((i_req.cursor_row != 2'd0) ? DDRAM_ROW1 : 8'h00)
                                    | {3'b000, i_req.cursor_column};
                            end
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (i_out_free) begin
                    o_ctl.adv = 1'b1;
                    n_pc      = r_pc + 7'd1;
                    if (cw.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= PC_INIT;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign o_stat.busy = (r_state == S_RUN);
    assign o_stat.pc   = r_pc;
endmodule

// File: rtl/core/clcd_datapath.sv
// Pin datapath: RS/enable/bus levels, request byte and the result register.
// Depends on clcd_pkg and clcd_res_if.
module clcd_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  clcd_pkg::t_ctl i_ctl,
    output logic           o_out_free,
    clcd_res_if.source     o_res
);
    import clcd_pkg::*;

    logic       r_rs, r_en;
    logic [3:0] r_bus;
    logic [7:0] r_byte;
    logic       r_rs_mode;
    logic       r_valid;
    logic [3:0] r_hold;
    logic       r_last;
    logic [3:0] nib;

    assign o_out_free = !r_valid || o_res.ready;

    always_comb begin
        case (i_ctl.cw.nsrc)
            NSRC_HI: nib = r_byte[7:4];
            NSRC_LO: nib = r_byte[3:0];
            default: nib = i_ctl.cw.nib;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs      <= 1'b0;
            r_en      <= 1'b0;
            r_bus     <= 4'h0;
            r_byte    <= 8'h00;
            r_rs_mode <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_ctl.ld) begin
                r_byte    <= i_ctl.ld_byte;
                r_rs_mode <= i_ctl.ld_rs;
            end
            if (i_ctl.adv) begin
                case (i_ctl.cw.op)
                    OP_RS:    r_rs  <= i_ctl.cw.rs_req && r_rs_mode;
                    OP_EN_HI: r_en  <= 1'b1;
                    OP_DATA:  r_bus <= nib;
                    OP_EN_LO: r_en  <= 1'b0;
                    default:  ;
                endcase
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_hold <= i_ctl.cw.hold;
            r_last <= i_ctl.cw.last;
        end
    end

    // pins only move when a beat is issued, so they equal the held beat's levels
    assign o_res.valid      = r_valid;
    assign o_res.rs_pin     = r_rs;
    assign o_res.enable_pin = r_en;
    assign o_res.data_pins  = r_bus;
    assign o_res.hold_ms    = r_hold;
    assign o_res.last_phase = r_last;
endmodule
